FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/ntpbso_pkg.sv
// ----------------------------------------------------------------------------
// ntpbso_pkg
// Types and constants shared by the NTP best-server offset block.
// ----------------------------------------------------------------------------
package ntpbso_pkg;

	localparam int STRATUM_W   = 8;
	localparam int TS_W        = 64;
	localparam int IDX_W       = 4;
	localparam int MAX_SERVERS = 16;
	localparam int CNT_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_DATA_W   = STRATUM_W + 4 * TS_W;
	localparam int RES_W       = IDX_W + STRATUM_W + 3 * TS_W;
	localparam int OUT_DATA_W  = ((RES_W + 7) / 8) * 8;

	// one classified measurement, front to back
	typedef struct packed {
		logic                 last;
		logic [STRATUM_W-1:0] stratum;
		logic [TS_W-1:0]      delay;
		logic [TS_W-1:0]      offset;
		logic [TS_W-1:0]      corrected;
	} meas_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// packed so that index lands in the lowest bits
	typedef struct packed {
		logic [TS_W-1:0]      corrected;
		logic [TS_W-1:0]      offset;
		logic [TS_W-1:0]      delay;
		logic [STRATUM_W-1:0] stratum;
		logic [IDX_W-1:0]     index;
	} result_t;

endpackage

FILE: rtl/core/ntpbso_front.sv
// ----------------------------------------------------------------------------
// ntpbso_front
// Input stage: accepts measurements and computes delay, offset and corrected
// time in a three-stage pipeline feeding the queue.
// ----------------------------------------------------------------------------
module ntpbso_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// stratum[7:0], t1[71:8], t2[135:72], t3[199:136], t4[263:200]
	input  logic [ntpbso_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                              s_tlast,
	input  ntpbso_pkg::q_status_t             q_status,
	output logic                              push,
	output ntpbso_pkg::meas_t                 push_data
);

	localparam int SW = ntpbso_pkg::STRATUM_W;
	localparam int TW = ntpbso_pkg::TS_W;

	logic [SW-1:0] in_stratum;
	logic [TW-1:0] t1, t2, t3, t4;
	logic          advance;

	logic          valid_s1, valid_s2, valid_s3;
	logic          last_s1, last_s2, last_s3;
	logic [SW-1:0] stratum_s1, stratum_s2, stratum_s3;
	logic [TW-1:0] d41_s1, d32_s1, d21_s1, d34_s1, t4_s1;
	logic [TW-1:0] delay_s2, offset_s2, t4_s2;
	logic [TW-1:0] delay_s3, offset_s3, corrected_s3;
	logic [TW:0]   sum_ext;

	assign in_stratum = s_tdata[SW-1:0];
	assign t1 = s_tdata[SW +: TW];
	assign t2 = s_tdata[SW + TW +: TW];
	assign t3 = s_tdata[SW + 2*TW +: TW];
	assign t4 = s_tdata[SW + 3*TW +: TW];

	assign advance  = !valid_s3 || !q_status.full;
	assign s_tready = advance;

	// exact signed sum, halved with arithmetic shift
	assign sum_ext = {d21_s1[TW-1], d21_s1} + {d34_s1[TW-1], d34_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1      <= s_tlast;
			stratum_s1   <= in_stratum;
			d41_s1       <= t4 - t1;
			d32_s1       <= t3 - t2;
			d21_s1       <= t2 - t1;
			d34_s1       <= t3 - t4;
			t4_s1        <= t4;

			last_s2      <= last_s1;
			stratum_s2   <= stratum_s1;
			delay_s2     <= d41_s1 - d32_s1;
			offset_s2    <= sum_ext[TW:1];
			t4_s2        <= t4_s1;

			last_s3      <= last_s2;
			stratum_s3   <= stratum_s2;
			delay_s3     <= delay_s2;
			offset_s3    <= offset_s2;
			corrected_s3 <= t4_s2 + offset_s2;
		end
	end

	assign push                = valid_s3 && !q_status.full;
	assign push_data.last      = last_s3;
	assign push_data.stratum   = stratum_s3;
	assign push_data.delay     = delay_s3;
	assign push_data.offset    = offset_s3;
	assign push_data.corrected = corrected_s3;

endmodule

FILE: rtl/core/ntpbso_queue.sv
// ----------------------------------------------------------------------------
// ntpbso_queue
// Short FIFO between front and back; head is shown without a read cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntpbso_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ntpbso_pkg::meas_t     push_data,
	input  logic                  pop,
	output ntpbso_pkg::meas_t     head,
	output ntpbso_pkg::q_status_t status
);

	localparam int DEPTH = ntpbso_pkg::QUEUE_DEPTH;
	localparam int PW    = ntpbso_pkg::QPTR_W;
	localparam int CW    = ntpbso_pkg::QCNT_W;

	ntpbso_pkg::meas_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && status.full, "push into full queue")
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && status.empty, "pop from empty queue")
	`ASSERT_CLK(a_count_range, clk, arst_n, (count_q <= CW'(DEPTH)), "queue count overflow")

endmodule

FILE: rtl/core/ntpbso_back.sv
// ----------------------------------------------------------------------------
// ntpbso_back
// Selection stage: keeps the best server of the round and emits it on the
// last measurement through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntpbso_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ntpbso_pkg::meas_t                 head,
	input  ntpbso_pkg::q_status_t             q_status,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// index[3:0], stratum[11:4], delay[75:12], offset[139:76],
	// corrected[203:140], zero pad[207:204]
	output logic [ntpbso_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int SW = ntpbso_pkg::STRATUM_W;
	localparam int TW = ntpbso_pkg::TS_W;
	localparam int IW = ntpbso_pkg::IDX_W;
	localparam int CW = ntpbso_pkg::CNT_W;

	logic [CW-1:0]       count_q;
	logic                have_best_q;
	logic [IW-1:0]       best_index_q;
	logic [SW-1:0]       best_stratum_q;
	logic [TW-1:0]       best_delay_q, best_offset_q, best_corr_q;
	logic                m_tvalid_q;
	ntpbso_pkg::result_t result_q;

	logic                take;
	ntpbso_pkg::result_t sel;

	assign pop = !q_status.empty && (!head.last || !m_tvalid_q || m_tready);

	always_comb begin
		if (!have_best_q) begin
			take = 1'b1;
		end else if (head.stratum < best_stratum_q) begin
			take = 1'b1;
		end else if (head.stratum == best_stratum_q) begin
			take = !($signed(best_delay_q) < $signed(head.delay));
		end else begin
			take = 1'b0;
		end

		if (take) begin
			sel.index     = IW'(count_q);
			sel.stratum   = head.stratum;
			sel.delay     = head.delay;
			sel.offset    = head.offset;
			sel.corrected = head.corrected;
		end else begin
			sel.index     = best_index_q;
			sel.stratum   = best_stratum_q;
			sel.delay     = best_delay_q;
			sel.offset    = best_offset_q;
			sel.corrected = best_corr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			have_best_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					count_q     <= '0;
					have_best_q <= 1'b0;
				end else begin
					count_q     <= (count_q == CW'(ntpbso_pkg::MAX_SERVERS - 1)) ?
						'0 : count_q + CW'(1);
					have_best_q <= 1'b1;
				end
			end
			if (pop && head.last) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			best_index_q   <= sel.index;
			best_stratum_q <= sel.stratum;
			best_delay_q   <= sel.delay;
			best_offset_q  <= sel.offset;
			best_corr_q    <= sel.corrected;
		end
		if (pop && head.last) begin
			result_q <= sel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(ntpbso_pkg::OUT_DATA_W - ntpbso_pkg::RES_W){1'b0}}, result_q};

	`ASSERT_CLK(a_last_emits, clk, arst_n, (pop && head.last) |=> m_tvalid_q, "no result")
	`ASSERT_CLK(a_last_clears, clk, arst_n, (pop && head.last) |=> !have_best_q, "not cleared")
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, pop && head.last && m_tvalid_q && !m_tready, "lost")

endmodule

FILE: rtl/core/ntp_best_server_offset.sv
// ----------------------------------------------------------------------------
// ntp_best_server_offset
// NTP best-server selection: per measurement delay and offset, best server
// kept per round (lowest stratum, then lowest delay, later wins ties).
//
//   channel  dir  transaction                         fields
//   s_*      in   one server measurement              tdata, tlast = last
//   m_*      out  chosen server of a finished round   tdata
//
// One measurement per cycle while the queue has room; three front pipeline
// stages feed a four-entry queue and then the selection register, and a
// result appears the cycle after the last measurement leaves the queue.
// Reset clears pipeline valids, queue pointers and round state; no sweep.
// A stalled output holds only the last measurement of the next round; the
// queue absorbs the stall, and the front stalls once the queue is full.
// ----------------------------------------------------------------------------
module ntp_best_server_offset (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// stratum[7:0], t1[71:8], t2[135:72], t3[199:136], t4[263:200]
	input  logic [ntpbso_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// index[3:0], stratum[11:4], delay[75:12], offset[139:76],
	// corrected[203:140], zero pad[207:204]
	output logic [ntpbso_pkg::OUT_DATA_W-1:0] m_tdata
);

	ntpbso_pkg::q_status_t q_status;
	ntpbso_pkg::meas_t     push_data, head;
	logic                  push, pop;

	ntpbso_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	ntpbso_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ntpbso_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: tb/tb_ntp_best_server_offset.sv
// ----------------------------------------------------------------------------
// tb_ntp_best_server_offset
// Streams server measurements into the block and checks every chosen-server
// transaction against an independent model of the best-server selection.
// A directed part hits the timestamp and stratum extremes, ties, signed
// delay order and offset rounding. Random rounds follow, some longer than
// the index range, under several patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_ntp_best_server_offset;

	localparam int STRATUM_W   = ntpbso_pkg::STRATUM_W;
	localparam int TS_W        = ntpbso_pkg::TS_W;
	localparam int IDX_W       = ntpbso_pkg::IDX_W;
	localparam int CNT_W       = ntpbso_pkg::CNT_W;
	localparam int MAX_SERVERS = ntpbso_pkg::MAX_SERVERS;
	localparam int IN_DATA_W   = ntpbso_pkg::IN_DATA_W;
	localparam int RES_W       = ntpbso_pkg::RES_W;
	localparam int OUT_DATA_W  = ntpbso_pkg::OUT_DATA_W;

	typedef ntpbso_pkg::result_t result_t;

	class best_server_tracker;
		logic [CNT_W-1:0]     round_pos;
		bit                   have_best;
		logic [IDX_W-1:0]     best_index;
		logic [STRATUM_W-1:0] best_stratum;
		logic [TS_W-1:0]      best_delay;
		logic [TS_W-1:0]      best_offset;
		logic [TS_W-1:0]      best_rx_time;
		result_t              expected_choices[$];
		int                   errors;

		function new();
			errors = 0;
			clear_round();
		endfunction

		function void clear_round();
			round_pos    = '0;
			have_best    = 0;
			best_index   = '0;
			best_stratum = '0;
			best_delay   = '0;
			best_offset  = '0;
			best_rx_time = '0;
		endfunction

		function void add_measurement(logic [STRATUM_W-1:0] st, logic [TS_W-1:0] t1,
				logic [TS_W-1:0] t2, logic [TS_W-1:0] t3, logic [TS_W-1:0] t4,
				logic last);
			logic [TS_W-1:0] delay;
			logic [TS_W-1:0] fwd;
			logic [TS_W-1:0] back;
			logic [TS_W:0]   sum;
			bit              take;
			result_t         choice;
			delay = (t4 - t1) - (t3 - t2);
			fwd   = t2 - t1;
			back  = t3 - t4;
			sum   = {fwd[TS_W-1], fwd} + {back[TS_W-1], back};
			if (!have_best)
				take = 1;
			else if (st < best_stratum)
				take = 1;
			else if (st == best_stratum)
				take = $signed(delay) <= $signed(best_delay);
			else
				take = 0;
			if (take) begin
				have_best    = 1;
				best_index   = IDX_W'(round_pos);
				best_stratum = st;
				best_delay   = delay;
				best_offset  = sum[TS_W:1];
				best_rx_time = t4;
			end
			round_pos = (round_pos == CNT_W'(MAX_SERVERS - 1)) ? '0 : round_pos + CNT_W'(1);
			if (last) begin
				choice.index     = best_index;
				choice.stratum   = best_stratum;
				choice.delay     = best_delay;
				choice.offset    = best_offset;
				choice.corrected = best_rx_time + best_offset;
				expected_choices.push_back(choice);
				clear_round();
			end
		endfunction

		function void compare_field(string name, logic [TS_W-1:0] exp_v,
				logic [TS_W-1:0] act_v);
			if (act_v !== exp_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v,
					act_v);
			end
		endfunction

		function void check_choice(result_t got);
			result_t want;
			if (expected_choices.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				return;
			end
			want = expected_choices.pop_front();
			compare_field("chosen_index", 64'(want.index), 64'(got.index));
			compare_field("chosen_stratum", 64'(want.stratum), 64'(got.stratum));
			compare_field("round_trip_delay", want.delay, got.delay);
			compare_field("clock_offset", want.offset, got.offset);
			compare_field("corrected_time", want.corrected, got.corrected);
		endfunction
	endclass

	localparam logic [TS_W-1:0] TS_ONES = '1;
	localparam logic [TS_W-1:0] TS_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [TS_W-1:0] TS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	best_server_tracker tracker = new();
	int                 source_idle_pct = 0;
	int                 sink_stall_pct = 0;
	int                 hold_off_cycles = 0;
	logic [STRATUM_W-1:0] prev_stratum;
	logic [TS_W-1:0]      prev_t1, prev_t2, prev_t3, prev_t4;

	ntp_best_server_offset dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [TS_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [TS_W-1:0] rand_delta();
		logic [TS_W-1:0] d;
		d = {32'd0, $urandom} >> $urandom_range(0, 31);
		if ($urandom_range(0, 1))
			d = -d;
		return d;
	endfunction

	// entered and left at a falling edge
	task automatic send_measurement(input logic [STRATUM_W-1:0] st,
			input logic [TS_W-1:0] t1, input logic [TS_W-1:0] t2,
			input logic [TS_W-1:0] t3, input logic [TS_W-1:0] t4, input logic last);
		while (source_idle_pct > 0 && $urandom_range(0, 99) < source_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {t4, t3, t2, t1, st};
		s_tlast  = last;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.add_measurement(st, t1, t2, t3, t4, last);
		@(negedge clk);
	endtask

	task automatic send_round(input int len);
		logic [STRATUM_W-1:0] st;
		logic [TS_W-1:0]      t1, t2, t3, t4, off, shift;
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 4) == 0) begin
				// same delay and offset as the previous server, shifted in time
				st    = prev_stratum;
				shift = rand64();
				t1    = prev_t1 + shift;
				t2    = prev_t2 + shift;
				t3    = prev_t3 + shift;
				t4    = prev_t4 + shift;
			end else begin
				st = ($urandom_range(0, 3) != 0) ? STRATUM_W'($urandom_range(0, 3)) :
					STRATUM_W'($urandom_range(0, 255));
				if ($urandom_range(0, 3) == 0) begin
					t1 = rand64();
					t2 = rand64();
					t3 = rand64();
					t4 = rand64();
				end else begin
					off = rand_delta();
					t1  = rand64();
					t2  = t1 + off + ({32'd0, $urandom} >> $urandom_range(8, 31));
					t3  = t2 + ({32'd0, $urandom} >> $urandom_range(8, 31));
					t4  = t3 - off + ({32'd0, $urandom} >> $urandom_range(8, 31));
				end
			end
			prev_stratum = st;
			prev_t1 = t1;
			prev_t2 = t2;
			prev_t3 = t3;
			prev_t4 = t4;
			send_measurement(st, t1, t2, t3, t4, i == len - 1);
		end
	endtask

	task automatic send_rounds(input int n_items, input int max_len);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) :
				$urandom_range(1, max_len);
			send_round(len);
			sent += len;
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready = 1'b0;
				hold_off_cycles--;
			end else begin
				m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
			end
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.check_choice(result_t'(m_tdata[RES_W-1:0]));
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-server rounds at the extremes
		send_measurement(8'd0, '0, '0, '0, '0, 1'b1);
		send_measurement(8'hFF, TS_ONES, TS_ONES, TS_ONES, TS_ONES, 1'b1);
		// lower stratum wins regardless of position
		send_measurement(8'hFF, '0, '0, '0, 64'd5, 1'b0);
		send_measurement(8'd0, '0, '0, '0, 64'd900, 1'b0);
		send_measurement(8'hFF, '0, '0, '0, '0, 1'b1);
		// exact tie: later server wins
		send_measurement(8'd5, 64'd100, 64'd300, 64'd350, 64'd170, 1'b0);
		send_measurement(8'd5, 64'd100, 64'd300, 64'd350, 64'd170, 1'b1);
		// delay order is signed
		send_measurement(8'd2, '0, '0, '0, 64'd1, 1'b0);
		send_measurement(8'd2, '0, '0, '0, TS_MIN, 1'b0);
		send_measurement(8'd2, '0, '0, '0, TS_MAX, 1'b1);
		// odd negative offset sum rounds down
		send_measurement(8'd1, '0, '0, '0, 64'd1, 1'b1);
		// offset sum beyond 64 bits, both directions
		send_measurement(8'd1, '0, TS_MAX, TS_MAX, '0, 1'b1);
		send_measurement(8'd1, '0, TS_MIN, TS_MIN, '0, 1'b1);
		// higher stratum loses even with lower delay
		send_measurement(8'd3, 64'd10, 64'd20, 64'd30, 64'd900, 1'b0);
		send_measurement(8'd4, 64'd10, 64'd20, 64'd30, 64'd41, 1'b1);
		send_measurement(8'd7, rand64(), rand64(), rand64(), rand64(), 1'b1);

		send_rounds(300, 6);

		source_idle_pct = 80;
		send_rounds(200, 6);

		source_idle_pct = 0;
		sink_stall_pct  = 80;
		send_rounds(200, 6);

		// sink holds off while the source keeps streaming
		sink_stall_pct  = 0;
		hold_off_cycles = 400;
		send_rounds(40, 3);

		source_idle_pct = 38;
		sink_stall_pct  = 38;
		send_rounds(210, 6);

		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (tracker.expected_choices.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb_ntp_best_server_offset passed");
		else
			$display("tb_ntp_best_server_offset failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_ntp_best_server_offset failed");
		$finish;
	end

endmodule
